FILE: design/lbsfd_pkg.sv
// Shared constants, codes and helper functions for the LED bar serial frame driver.
`default_nettype none

package lbsfd_pkg;

    localparam int CHANNELS    = 12;
    localparam int FRAME_WORDS = CHANNELS + 1;
    localparam int WORD_W      = $clog2(FRAME_WORDS + 1);

    // stream kind codes
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_MASK  = 2'd1;
    localparam logic [1:0] KIND_LEVEL = 2'd2;

    // configuration register indexes
    localparam logic CFG_LATCH_WAIT = 1'b0;
    localparam logic CFG_PULSE_GAP  = 1'b1;

    localparam logic [15:0] LATCH_WAIT_RST = 16'd250;
    localparam logic [7:0]  PULSE_GAP_RST  = 8'd1;

    localparam logic [6:0]  LEVEL_MAX    = 7'd100;
    localparam logic [15:0] MASK_WORD    = 16'h00FF;
    localparam logic [15:0] FULL_WORD    = 16'h03FF;
    localparam logic [2:0]  LATCH_PULSES = 3'd4;

    // partial-channel word, index saturated at 10 by the caller
    function automatic logic [15:0] level_word(input logic [3:0] k);
        logic [15:0] w;
        unique case (k)
            4'd0:    w = 16'h0000;
            4'd1:    w = 16'h0001;
            4'd2:    w = 16'h0003;
            4'd3:    w = 16'h0007;
            4'd4:    w = 16'h000F;
            4'd5:    w = 16'h001F;
            4'd6:    w = 16'h003F;
            4'd7:    w = 16'h00FF;
            4'd8:    w = 16'h01FF;
            default: w = 16'h03FF;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/led_bar_serial_frame_driver.sv
// Top level: LED bar serial frame sequencer with stream input and result channels.
//
//  channel | direction | handshake                      | payload
//  s_axis  | in        | s_axis_tvalid / s_axis_tready  | tdata: value, tuser: kind
//  m_axis  | out       | m_axis_tvalid / m_axis_tready  | tdata: pin levels, busy, rejected
//  cfg     | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// One item in, one result out; the sequencer state and the result in a single output
// register are both loaded at the input transfer.
// A new item is taken whenever the output register is empty or being drained.
// rst_n clears the sequencer to idle and loads the register reset values.
// A stalled m_axis holds its result and stops input only while the register is full.
`default_nettype none

module led_bar_serial_frame_driver
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] clock_level [1] data_level
                                             // [2] busy_res [3] rejected [7:4] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SEND  = 3'd1;
    localparam logic [2:0] PH_WAIT  = 3'd2;
    localparam logic [2:0] PH_PULSE = 3'd3;
    localparam logic [2:0] PH_GAP   = 3'd4;

    localparam int WW = lbsfd_pkg::WORD_W;
    localparam logic [WW-1:0] LAST_WORD = WW'(lbsfd_pkg::FRAME_WORDS - 1);

    logic [15:0]   latch_wait_reg;
    logic [7:0]    pulse_gap_reg;
    logic [9:0]    held_mask_reg,   held_mask_next;
    logic [6:0]    held_level_reg,  held_level_next;
    logic          level_mode_reg,  level_mode_next;
    logic [WW-1:0] word_count_reg,  word_count_next;
    logic [3:0]    bit_count_reg,   bit_count_next;
    logic [2:0]    phase_reg,       phase_next;
    logic [15:0]   wait_count_reg,  wait_count_next;
    logic [2:0]    pulse_count_reg, pulse_count_next;
    logic          clock_reg,       clock_next;
    logic          data_reg,        data_next;
    logic          rej_next;

    logic          out_valid_reg;
    logic [7:0]    out_data_reg;

    logic          in_xfer;
    logic [WW-1:0] ch;
    logic [3:0]    ch4;
    logic [6:0]    mark;
    logic [6:0]    lvl_k;
    logic [15:0]   chan_word;
    logic [15:0]   frame_word;
    logic [15:0]   latch_wait_eff;
    logic [7:0]    pulse_gap_eff;
    logic [16:0]   wait_inc;
    logic [6:0]    level_sat;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // channel word for the word in flight
    assign ch   = word_count_reg - WW'(1);
    assign ch4  = 4'(ch);
    assign mark = 7'(7'd90 - 7'(ch4) * 7'd10);
    assign lvl_k = held_level_reg - mark;

    always_comb
    begin
        chan_word = 16'h0000;
        if (int'(ch) < 10)
        begin
            if (!level_mode_reg)
            begin
                if (((held_mask_reg >> (4'd9 - ch4)) & 10'd1) != 10'd0)
                    chan_word = lbsfd_pkg::MASK_WORD;
            end
            else if (held_level_reg >= mark)
            begin
                if (ch4 == 4'd0 || held_level_reg < mark + 7'd10)
                    chan_word = lbsfd_pkg::level_word((lvl_k > 7'd10) ? 4'd10 : 4'(lvl_k));
                else
                    chan_word = lbsfd_pkg::FULL_WORD;
            end
        end
    end

    assign frame_word     = (word_count_reg == '0) ? 16'h0000 : chan_word;
    assign latch_wait_eff = (latch_wait_reg == 16'd0) ? 16'd1 : latch_wait_reg;
    assign pulse_gap_eff  = (pulse_gap_reg == 8'd0) ? 8'd1 : pulse_gap_reg;
    assign wait_inc       = {1'b0, wait_count_reg} + 17'd1;
    assign level_sat      = (s_axis_tdata > 16'(lbsfd_pkg::LEVEL_MAX)) ?
                            lbsfd_pkg::LEVEL_MAX : s_axis_tdata[6:0];

    always_comb
    begin
        held_mask_next   = held_mask_reg;
        held_level_next  = held_level_reg;
        level_mode_next  = level_mode_reg;
        word_count_next  = word_count_reg;
        bit_count_next   = bit_count_reg;
        phase_next       = phase_reg;
        wait_count_next  = wait_count_reg;
        pulse_count_next = pulse_count_reg;
        clock_next       = clock_reg;
        data_next        = data_reg;
        rej_next         = 1'b0;

        if (s_axis_tuser == lbsfd_pkg::KIND_TICK)
        begin
            unique case (phase_reg)
                PH_SEND:
                begin
                    data_next      = frame_word[~bit_count_reg];
                    clock_next     = !clock_reg;
                    bit_count_next = bit_count_reg + 4'd1;
                    if (bit_count_reg == 4'd15)
                    begin
                        word_count_next = word_count_reg + WW'(1);
                        if (word_count_reg == LAST_WORD)
                        begin
                            word_count_next = '0;
                            phase_next      = PH_WAIT;
                            wait_count_next = 16'd0;
                        end
                    end
                end
                PH_WAIT:
                begin
                    data_next       = 1'b0;
                    wait_count_next = wait_inc[15:0];
                    if (wait_inc >= {1'b0, latch_wait_eff})
                    begin
                        wait_count_next  = 16'd0;
                        pulse_count_next = 3'd0;
                        phase_next       = PH_PULSE;
                    end
                end
                PH_PULSE:
                begin
                    data_next       = 1'b1;
                    wait_count_next = 16'd0;
                    phase_next      = PH_GAP;
                end
                PH_GAP:
                begin
                    data_next       = 1'b0;
                    wait_count_next = wait_inc[15:0];
                    if (wait_inc >= 17'(pulse_gap_eff))
                    begin
                        wait_count_next = 16'd0;
                        if (pulse_count_reg + 3'd1 >= lbsfd_pkg::LATCH_PULSES)
                        begin
                            pulse_count_next = 3'd0;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            pulse_count_next = pulse_count_reg + 3'd1;
                            phase_next       = PH_PULSE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (s_axis_tuser == lbsfd_pkg::KIND_MASK || s_axis_tuser == lbsfd_pkg::KIND_LEVEL)
        begin
            if (phase_reg != PH_IDLE)
                rej_next = 1'b1;
            else
            begin
                level_mode_next = (s_axis_tuser == lbsfd_pkg::KIND_LEVEL);
                if (s_axis_tuser == lbsfd_pkg::KIND_MASK)
                    held_mask_next = s_axis_tdata[9:0];
                else
                    held_level_next = level_sat;
                word_count_next  = '0;
                bit_count_next   = 4'd0;
                wait_count_next  = 16'd0;
                pulse_count_next = 3'd0;
                phase_next       = PH_SEND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_wait_reg  <= lbsfd_pkg::LATCH_WAIT_RST;
            pulse_gap_reg   <= lbsfd_pkg::PULSE_GAP_RST;
            held_mask_reg   <= '0;
            held_level_reg  <= '0;
            level_mode_reg  <= 1'b0;
            word_count_reg  <= '0;
            bit_count_reg   <= '0;
            phase_reg       <= PH_IDLE;
            wait_count_reg  <= '0;
            pulse_count_reg <= '0;
            clock_reg       <= 1'b0;
            data_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    lbsfd_pkg::CFG_LATCH_WAIT: latch_wait_reg <= cfg_data;
                    lbsfd_pkg::CFG_PULSE_GAP:  pulse_gap_reg  <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_xfer)
            begin
                held_mask_reg   <= held_mask_next;
                held_level_reg  <= held_level_next;
                level_mode_reg  <= level_mode_next;
                word_count_reg  <= word_count_next;
                bit_count_reg   <= bit_count_next;
                phase_reg       <= phase_next;
                wait_count_reg  <= wait_count_next;
                pulse_count_reg <= pulse_count_next;
                clock_reg       <= clock_next;
                data_reg        <= data_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            out_data_reg <= {4'b0000, rej_next, (phase_next != PH_IDLE), data_next, clock_next};
    end

`ifndef NO_ASSERTIONS
    // a dropped command only happens while a sequence runs
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[3]) |-> out_data_reg[2])
        else $error("rejected result without busy");

    // the clock pin only moves on a transfer
    a_clock_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_xfer |=> $stable(clock_reg))
        else $error("clock pin changed without a transfer");

    // idle sequencer keeps its frame counters cleared
    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bit_count_reg == 4'd0 && word_count_reg == '0))
        else $error("frame counters not clear while idle");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/frame_pin_checker.sv
// Checker: predicts clock/data pin levels of the LED bar frame sequencer and compares results.
`timescale 1ns / 100ps

module frame_pin_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,   // [0] clock_level [1] data_level
                                             // [2] busy_res [3] rejected [7:4] zero
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               failures,
    output int               pending
);

    typedef enum logic [2:0] {SEQ_IDLE, SEQ_SEND, SEQ_WAIT, SEQ_PULSE, SEQ_GAP} seq_phase_t;

    typedef struct packed {
        logic rejected;
        logic busy;
        logic dat_lvl;
        logic clk_lvl;
    } pin_status_t;

    logic [15:0] latch_wait = lbsfd_pkg::LATCH_WAIT_RST;
    logic [7:0]  pulse_gap  = lbsfd_pkg::PULSE_GAP_RST;

    logic [9:0]  seg_mask    = '0;
    logic [6:0]  bar_level   = '0;
    logic        show_level  = 1'b0;
    logic [3:0]  word_idx    = '0;
    logic [3:0]  bit_idx     = '0;
    seq_phase_t  seq         = SEQ_IDLE;
    logic [15:0] tick_count  = '0;
    logic [2:0]  pulses_done = '0;
    logic        clk_line    = 1'b0;
    logic        dat_line    = 1'b0;

    pin_status_t status_due[$];
    pin_status_t next_status;
    pin_status_t want;
    int          fail_total = 0;

    assign failures = fail_total;

    // bar word for one channel; level mode fills from the top channel down
    function automatic logic [15:0] bar_word(input int ch);
        int mark;
        int k;
        if (ch >= 10)
            return 16'h0000;
        if (!show_level)
            return seg_mask[9 - ch] ? lbsfd_pkg::MASK_WORD : 16'h0000;
        mark = 90 - 10 * ch;
        if (bar_level < mark)
            return 16'h0000;
        if (ch != 0 && bar_level >= mark + 10)
            return lbsfd_pkg::FULL_WORD;
        k = bar_level - mark;
        // partial table skips 0x7F: entries 7..9 are one bit wider than their index
        if (k <= 6)
            return (16'd1 << k) - 16'd1;
        if (k <= 9)
            return (16'd1 << (k + 1)) - 16'd1;
        return lbsfd_pkg::FULL_WORD;
    endfunction

    task automatic advance_pins();
        logic [15:0] w;
        logic [15:0] wait_eff;
        logic [7:0]  gap_eff;
        wait_eff = (latch_wait == 0) ? 16'd1 : latch_wait;
        gap_eff  = (pulse_gap == 0) ? 8'd1 : pulse_gap;
        case (seq)
            SEQ_SEND:
            begin
                w = (word_idx == 0) ? 16'h0000 : bar_word(word_idx - 1);
                dat_line = w[15 - bit_idx];
                clk_line = ~clk_line;
                if (bit_idx == 4'd15)
                begin
                    bit_idx = '0;
                    if (word_idx == lbsfd_pkg::FRAME_WORDS - 1)
                    begin
                        word_idx   = '0;
                        tick_count = '0;
                        seq        = SEQ_WAIT;
                    end
                    else
                        word_idx = word_idx + 4'd1;
                end
                else
                    bit_idx = bit_idx + 4'd1;
            end
            SEQ_WAIT:
            begin
                dat_line   = 1'b0;
                tick_count = tick_count + 16'd1;
                if (tick_count >= wait_eff)
                begin
                    tick_count  = '0;
                    pulses_done = '0;
                    seq         = SEQ_PULSE;
                end
            end
            SEQ_PULSE:
            begin
                dat_line   = 1'b1;
                tick_count = '0;
                seq        = SEQ_GAP;
            end
            SEQ_GAP:
            begin
                dat_line   = 1'b0;
                tick_count = tick_count + 16'd1;
                if (tick_count >= gap_eff)
                begin
                    tick_count  = '0;
                    pulses_done = pulses_done + 3'd1;
                    if (pulses_done == lbsfd_pkg::LATCH_PULSES)
                    begin
                        pulses_done = '0;
                        seq         = SEQ_IDLE;
                    end
                    else
                        seq = SEQ_PULSE;
                end
            end
            default: ;
        endcase
    endtask

    task automatic take_item(input logic [1:0] kind, input logic [15:0] value,
                             output pin_status_t status);
        status.rejected = 1'b0;
        case (kind)
            lbsfd_pkg::KIND_TICK:
                advance_pins();
            lbsfd_pkg::KIND_MASK, lbsfd_pkg::KIND_LEVEL:
            begin
                if (seq != SEQ_IDLE)
                    status.rejected = 1'b1;
                else
                begin
                    show_level = (kind == lbsfd_pkg::KIND_LEVEL);
                    if (kind == lbsfd_pkg::KIND_MASK)
                        seg_mask = value[9:0];
                    else
                        bar_level = (value > lbsfd_pkg::LEVEL_MAX) ?
                                    lbsfd_pkg::LEVEL_MAX : value[6:0];
                    word_idx    = '0;
                    bit_idx     = '0;
                    tick_count  = '0;
                    pulses_done = '0;
                    seq         = SEQ_SEND;
                end
            end
            default: ;
        endcase
        status.clk_lvl = clk_line;
        status.dat_lvl = dat_line;
        status.busy    = (seq != SEQ_IDLE);
    endtask

    task automatic check_field(input string name, input logic [3:0] exp_val,
                               input logic [3:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_val, got_val);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_wait  = lbsfd_pkg::LATCH_WAIT_RST;
            pulse_gap   = lbsfd_pkg::PULSE_GAP_RST;
            seg_mask    = '0;
            bar_level   = '0;
            show_level  = 1'b0;
            word_idx    = '0;
            bit_idx     = '0;
            seq         = SEQ_IDLE;
            tick_count  = '0;
            pulses_done = '0;
            clk_line    = 1'b0;
            dat_line    = 1'b0;
            status_due.delete();
        end
        else
        begin
            // results leave before this edge's input is queued
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (status_due.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, got %h",
                             $time, m_axis_tdata);
                    fail_total++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("clock_level", 4'(want.clk_lvl), 4'(m_axis_tdata[0]));
                    check_field("data_level", 4'(want.dat_lvl), 4'(m_axis_tdata[1]));
                    check_field("busy_res", 4'(want.busy), 4'(m_axis_tdata[2]));
                    check_field("rejected", 4'(want.rejected), 4'(m_axis_tdata[3]));
                    check_field("tdata padding", 4'h0, m_axis_tdata[7:4]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                take_item(s_axis_tuser, s_axis_tdata, next_status);
                status_due.push_back(next_status);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lbsfd_pkg::CFG_LATCH_WAIT)
                    latch_wait = cfg_data;
                else
                    pulse_gap = cfg_data[7:0];
            end
        end
        pending = status_due.size();
    end

endmodule

FILE: tb/sv/led_bar_serial_frame_driver_test.sv
// Testbench top: drives commands, ticks and register writes into the LED bar frame driver.
`timescale 1ns / 100ps

module led_bar_serial_frame_driver_test;

    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam int         FRAME_BITS   = lbsfd_pkg::FRAME_WORDS * 16;
    localparam int         RANDOM_ITEMS = 400;
    localparam longint     CYCLE_LIMIT  = 4_000_000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] value
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] clock_level [1] data_level
                                       // [2] busy_res [3] rejected [7:4] zero
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_index     = 1'b0;
    logic [15:0] cfg_data      = '0;

    int          failures;
    int          pending;

    // mirror of the registers and of the sequencer's remaining ticks, for pacing only
    logic [15:0] wait_now   = lbsfd_pkg::LATCH_WAIT_RST;
    logic [7:0]  gap_now    = lbsfd_pkg::PULSE_GAP_RST;
    int          ticks_left = 0;
    int          burst_left = 0;
    int          items_sent = 0;
    longint      cycle_count = 0;
    int          ready_hold = 0;
    int          ready_mode = 0;
    logic [7:0]  ready_ctr  = '0;

    logic [15:0] directed_levels [13] = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd37,
                                          16'd89, 16'd90, 16'd91, 16'd99, 16'd100,
                                          16'd101, 16'hFFFF};
    logic [15:0] directed_masks [3] = '{16'h0000, 16'hFD55, 16'h02AA};

    always #5 clk = ~clk;

    led_bar_serial_frame_driver DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    frame_pin_checker pin_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .pending       (pending)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("led_bar_serial_frame_driver verification failed");
            $finish;
        end
    end

    // result side: stall modes held for random stretches, mode 0 never stalls
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(16, 400);
        end
        ready_hold--;
        ready_ctr++;
        case (ready_mode)
            0:       m_axis_tready = 1'b1;
            1:       m_axis_tready = ($urandom_range(0, 3) != 0);
            2:       m_axis_tready = 1'($urandom_range(0, 1));
            default: m_axis_tready = (ready_ctr[2:0] == 3'd0);
        endcase
    end

    function automatic int frame_ticks();
        int wait_eff;
        int gap_eff;
        wait_eff = (wait_now == 0) ? 1 : int'(wait_now);
        gap_eff  = (gap_now == 0) ? 1 : int'(gap_now);
        return FRAME_BITS + wait_eff + int'(lbsfd_pkg::LATCH_PULSES) * (1 + gap_eff);
    endfunction

    // called at a falling edge; valid stays high into the next call unless a gap starts
    task automatic send_item(input logic [1:0] kind, input logic [15:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
        if (kind == lbsfd_pkg::KIND_TICK && ticks_left > 0)
            ticks_left--;
        else if ((kind == lbsfd_pkg::KIND_MASK || kind == lbsfd_pkg::KIND_LEVEL) &&
                 ticks_left == 0)
            ticks_left = frame_ticks();
    endtask

    // tick the sequencer back to idle; noisy adds dropped commands and spare kinds
    task automatic finish_frame(input bit noisy);
        int r;
        while (ticks_left > 0)
        begin
            r = noisy ? $urandom_range(0, 99) : 99;
            if (r < 3)
                send_item($urandom_range(0, 1) ? lbsfd_pkg::KIND_MASK : lbsfd_pkg::KIND_LEVEL,
                          16'($urandom));
            else if (r < 6)
                send_item(KIND_SPARE, 16'($urandom));
            else
                send_item(lbsfd_pkg::KIND_TICK, 16'($urandom));
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == lbsfd_pkg::CFG_LATCH_WAIT)
            wait_now = data;
        else
            gap_now = data[7:0];
    endtask

    // only between frames, once every result has been taken
    task automatic set_config(input logic [15:0] latch_wait, input logic [7:0] pulse_gap);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        write_reg(lbsfd_pkg::CFG_LATCH_WAIT, latch_wait);
        write_reg(lbsfd_pkg::CFG_PULSE_GAP, {8'($urandom), pulse_gap});
    endtask

    initial
    begin
        int          start_count;
        logic [1:0]  kind;
        logic [15:0] value;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values; idle tick and spare kind first
        send_item(lbsfd_pkg::KIND_TICK, 16'hFFFF);
        send_item(KIND_SPARE, 16'h0000);
        send_item(lbsfd_pkg::KIND_MASK, 16'h03FF);
        send_item(lbsfd_pkg::KIND_LEVEL, 16'd50);
        send_item(KIND_SPARE, 16'hFFFF);
        send_item(lbsfd_pkg::KIND_MASK, 16'h0000);
        finish_frame(1'b0);

        set_config(16'd3, 8'd2);
        foreach (directed_masks[i])
        begin
            send_item(lbsfd_pkg::KIND_MASK, directed_masks[i]);
            finish_frame(1'b0);
        end
        foreach (directed_levels[i])
        begin
            send_item(lbsfd_pkg::KIND_LEVEL, directed_levels[i]);
            finish_frame(1'b0);
        end

        // zero registers behave as one
        set_config(16'd0, 8'd0);
        send_item(lbsfd_pkg::KIND_LEVEL, 16'd64);
        finish_frame(1'b1);

        set_config(16'hFFFF, 8'hFF);
        send_item(lbsfd_pkg::KIND_MASK, 16'($urandom));
        finish_frame(1'b1);

        set_config(16'd1, 8'd1);
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                set_config(16'($urandom_range(1, 8)), 8'($urandom_range(1, 3)));
            repeat ($urandom_range(0, 2))
                send_item($urandom_range(0, 1) ? lbsfd_pkg::KIND_TICK : KIND_SPARE,
                          16'($urandom));
            kind = $urandom_range(0, 1) ? lbsfd_pkg::KIND_MASK : lbsfd_pkg::KIND_LEVEL;
            if (kind == lbsfd_pkg::KIND_LEVEL && $urandom_range(0, 3) != 0)
                value = 16'($urandom_range(0, 110));
            else
                value = 16'($urandom);
            send_item(kind, value);
            finish_frame(1'b1);
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("led_bar_serial_frame_driver verification clean");
        else
            $display("led_bar_serial_frame_driver verification failed");
        $finish;
    end

endmodule
